// ----- hdl/pffa_pkg.sv -----
// pffa_pkg: shared types, codes and constants for the job allocator
// no dependencies; compiled first
package pffa_pkg;

   // parameter defaults
   localparam int unsigned NODE_COUNT_DEF  = 128;
   localparam int unsigned QUEUE_DEPTH_DEF = 16;

   // register reset values
   localparam logic [1:0] POLICY_RESET = 2'd0;
   localparam logic [7:0] CORES_RESET  = 8'd24;
   localparam logic [9:0] MEMORY_RESET = 10'd64;
   localparam logic [7:0] NODES_RESET  = 8'd128;

   // configuration register indexes
   localparam logic [7:0] REG_POLICY = 8'd0;
   localparam logic [7:0] REG_CORES  = 8'd1;
   localparam logic [7:0] REG_MEMORY = 8'd2;
   localparam logic [7:0] REG_NODES  = 8'd3;

   // command queue between front and back
   localparam int unsigned FIFO_DEPTH = 2;
   localparam int unsigned FIFO_PTR_W = 1;
   localparam int unsigned FIFO_CNT_W = 2;

   localparam int unsigned PROD_W   = 34;
   localparam int unsigned NODE_W   = 18;

   typedef enum logic [1:0] {
      OP_ENQUEUE  = 2'd0,
      OP_SCHEDULE = 2'd1,
      OP_RELEASE  = 2'd2,
      OP_NONE     = 2'd3
   } op_type;

   typedef enum logic [1:0] {
      ST_ALLOCATED     = 2'd0,
      ST_NOT_ALLOCATED = 2'd1,
      ST_QUEUED        = 2'd2,
      ST_FULL          = 2'd3
   } status_type;

   typedef enum logic [1:0] {
      POL_ARRIVAL  = 2'd0,
      POL_PRODUCT  = 2'd1,
      POL_RUNTIME  = 2'd2,
      POL_RESERVED = 2'd3
   } policy_type;

   typedef enum logic [1:0] {
      F_IDLE,
      F_MUL,
      F_PUSH
   } front_state_type;

   typedef enum logic [3:0] {
      B_IDLE,
      B_ENQ_EMIT,
      B_REL_RD,
      B_REL_WR,
      B_SEL_RD,
      B_SEL_CMP,
      B_NODE_RD,
      B_NODE_CMP,
      B_EMIT
   } back_state_type;

   // classified command handed from front to back
   typedef struct packed {
      logic [1:0]        op;
      logic [15:0]       job_id;
      logic [7:0]        cores;
      logic [9:0]        memory;
      logic [15:0]       run_time;
      logic [6:0]        target_node;
      logic [PROD_W-1:0] product;
   } cmd_type;

   // one queued job as held in the job store
   typedef struct packed {
      logic [15:0]       job_id;
      logic [7:0]        cores;
      logic [9:0]        memory;
      logic [15:0]       run_time;
      logic [PROD_W-1:0] product;
   } job_type;

   localparam int unsigned JOB_W = $bits(job_type);

   // ordering key of a job under the current policy
   function automatic logic [PROD_W-1:0] key_of(input logic [1:0] policy,
                                                input job_type job);
      logic [PROD_W-1:0] key;
      case (policy_type'(policy))
         POL_PRODUCT: key = job.product;
         POL_RUNTIME: key = PROD_W'(job.run_time);
         default:     key = '0;
      endcase
      return key;
   endfunction

endpackage

// ----- hdl/pffa_channels.sv -----
// pffa channel interfaces: request, response and register write channels
// no dependencies
interface pffa_req_if;
   logic        valid;
   logic        ready;
   logic [1:0]  op;
   logic [15:0] job_id;
   logic [7:0]  cores_needed;
   logic [9:0]  memory_needed;
   logic [15:0] run_time;
   logic [6:0]  target_node;

   modport source (output valid, op, job_id, cores_needed, memory_needed, run_time,
                   target_node, input ready);
   modport sink (input valid, op, job_id, cores_needed, memory_needed, run_time,
                 target_node, output ready);
endinterface

interface pffa_rsp_if;
   logic        valid;
   logic        ready;
   logic [15:0] result_job;
   logic [1:0]  status;
   logic [6:0]  chosen_node;
   logic        last;

   modport source (output valid, result_job, status, chosen_node, last, input ready);
   modport sink (input valid, result_job, status, chosen_node, last, output ready);
endinterface

interface pffa_csr_if;
   logic       valid;
   logic       ready;
   logic [7:0] index;
   logic [9:0] data;

   modport source (output valid, index, data, input ready);
   modport sink (input valid, index, data, output ready);
endinterface

// ----- hdl/priority_first_fit_job_allocator_core.sv -----
// priority_first_fit_job_allocator_core: top level of the job allocator
// depends on pffa_pkg, pffa_channels, pffa_front, pffa_cmd_fifo, pffa_back
//
// Jobs are enqueued (one result: queued or queue full), a schedule item drains the
// queue in policy order giving one result per job (allocated node or not
// allocated, last set on the final one), a release item returns resources to a
// node and gives no result. The front takes a new item only once it has pushed
// the last one into the command queue. In the back an enqueue passes through
// the enqueue emit state and a release through a node table read and write; a
// schedule, for each job, scans the queue through the job store read port for
// the ordering, then searches the nodes in use first fit through the node table
// read port, then hands over the result. Node free amounts reset through
// per-node valid bits, so there is no clearing pass after reset.
module priority_first_fit_job_allocator_core #(
   parameter int unsigned NODE_COUNT  = pffa_pkg::NODE_COUNT_DEF,
   parameter int unsigned QUEUE_DEPTH = pffa_pkg::QUEUE_DEPTH_DEF
) (
   input logic        clock,
   input logic        reset,
   pffa_req_if.sink   req_ch,
   pffa_rsp_if.source rsp_ch,
   pffa_csr_if.sink   csr_ch
);
   import pffa_pkg::*;

   cmd_type front_cmd, back_cmd;
   logic    front_valid, front_ready, back_valid, back_ready;
   logic [$clog2(QUEUE_DEPTH+1)-1:0] queue_count;

   // front: accept and classify
   pffa_front u_front (
      .clock     (clock),
      .reset     (reset),
      .req_ch    (req_ch),
      .cmd_out   (front_cmd),
      .cmd_valid (front_valid),
      .cmd_ready (front_ready)
   );

   // command queue
   pffa_cmd_fifo u_fifo (
      .clock      (clock),
      .reset      (reset),
      .push_data  (front_cmd),
      .push_valid (front_valid),
      .push_ready (front_ready),
      .pop_data   (back_cmd),
      .pop_valid  (back_valid),
      .pop_ready  (back_ready)
   );

   // back: store, order, allocate
   pffa_back #(.NODE_COUNT(NODE_COUNT), .QUEUE_DEPTH(QUEUE_DEPTH)) u_back (
      .clock       (clock),
      .reset       (reset),
      .cmd_in      (back_cmd),
      .cmd_valid   (back_valid),
      .cmd_ready   (back_ready),
      .csr_ch      (csr_ch),
      .rsp_ch      (rsp_ch),
      .queue_count (queue_count)
   );

   // checks
   a_count_range: assert property (@(posedge clock) disable iff (reset)
      queue_count <= ($clog2(QUEUE_DEPTH+1))'(QUEUE_DEPTH))
      else $error("queue count beyond depth");

   a_node_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_ch.valid && rsp_ch.status != ST_ALLOCATED |-> rsp_ch.chosen_node == '0)
      else $error("node set on a result that is not an allocation");

   a_enq_last: assert property (@(posedge clock) disable iff (reset)
      rsp_ch.valid && (rsp_ch.status == ST_QUEUED || rsp_ch.status == ST_FULL)
      |-> rsp_ch.last)
      else $error("enqueue result without last");

   a_full_count: assert property (@(posedge clock) disable iff (reset)
      rsp_ch.valid && !$past(rsp_ch.valid) && rsp_ch.status == ST_FULL
      |-> queue_count == ($clog2(QUEUE_DEPTH+1))'(QUEUE_DEPTH))
      else $error("queue full reported with room left");
endmodule

// ----- hdl/pffa_ram.sv -----
// pffa_ram: generic single write port, single read port ram, registered read
// no dependencies
module pffa_ram #(
   parameter int unsigned WIDTH = 8,
   parameter int unsigned DEPTH = 16
) (
   input  logic                                  clock,
   input  logic                                  we,
   input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
   input  logic [WIDTH-1:0]                      wdata,
   input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
   output logic [WIDTH-1:0]                      rdata
);
   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   // write and registered read
   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[waddr] <= wdata;
      end
      rdata_ff <= mem_ff[raddr];
   end

   assign rdata = rdata_ff;
endmodule

// ----- hdl/pffa_front.sv -----
// pffa_front: accepts request items and builds the command, including the
// resource product; depends on pffa_pkg and pffa_channels
module pffa_front (
   input  logic              clock,
   input  logic              reset,
   pffa_req_if.sink          req_ch,
   output pffa_pkg::cmd_type cmd_out,
   output logic              cmd_valid,
   input  logic              cmd_ready
);
   import pffa_pkg::*;

   front_state_type state_ff, state_in;
   cmd_type         cmd_ff;
   logic [23:0]     part_ff;

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         F_IDLE:  if (req_ch.valid) state_in = F_MUL;
         F_MUL:   state_in = F_PUSH;
         F_PUSH:  if (cmd_ready) state_in = F_IDLE;
         default: state_in = F_IDLE;
      endcase
   end

   // outputs: second multiply feeds the queue register directly
   always_comb begin
      req_ch.ready = (state_ff == F_IDLE);
      cmd_valid    = (state_ff == F_PUSH);
      cmd_out      = cmd_ff;
      cmd_out.product = PROD_W'(part_ff) * PROD_W'(cmd_ff.memory);
   end

   // capture item, then run time times cores
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= F_IDLE;
      end else begin
         state_ff <= state_in;
      end
      if (state_ff == F_IDLE && req_ch.valid) begin
         cmd_ff.op          <= req_ch.op;
         cmd_ff.job_id      <= req_ch.job_id;
         cmd_ff.cores       <= req_ch.cores_needed;
         cmd_ff.memory      <= req_ch.memory_needed;
         cmd_ff.run_time    <= req_ch.run_time;
         cmd_ff.target_node <= req_ch.target_node;
         cmd_ff.product     <= '0;
      end
      if (state_ff == F_MUL) begin
         part_ff <= 24'(cmd_ff.run_time) * 24'(cmd_ff.cores);
      end
   end
endmodule

// ----- hdl/pffa_cmd_fifo.sv -----
// pffa_cmd_fifo: short command queue between front and back
// depends on pffa_pkg
module pffa_cmd_fifo (
   input  logic              clock,
   input  logic              reset,
   input  pffa_pkg::cmd_type push_data,
   input  logic              push_valid,
   output logic              push_ready,
   output pffa_pkg::cmd_type pop_data,
   output logic              pop_valid,
   input  logic              pop_ready
);
   import pffa_pkg::*;

   cmd_type               mem_ff [FIFO_DEPTH];
   logic [FIFO_PTR_W-1:0] wr_ptr_ff, rd_ptr_ff;
   logic [FIFO_CNT_W-1:0] cnt_ff;
   logic                  push, pop;

   assign push_ready = (cnt_ff != FIFO_CNT_W'(FIFO_DEPTH));
   assign pop_valid  = (cnt_ff != '0);
   assign push       = push_valid && push_ready;
   assign pop        = pop_ready && pop_valid;
   assign pop_data   = mem_ff[rd_ptr_ff];

   // pointers and fill count
   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         cnt_ff    <= '0;
      end else begin
         if (push) wr_ptr_ff <= wr_ptr_ff + FIFO_PTR_W'(1);
         if (pop)  rd_ptr_ff <= rd_ptr_ff + FIFO_PTR_W'(1);
         if (push && !pop) cnt_ff <= cnt_ff + FIFO_CNT_W'(1);
         else if (pop && !push) cnt_ff <= cnt_ff - FIFO_CNT_W'(1);
      end
      if (push) mem_ff[wr_ptr_ff] <= push_data;
   end
endmodule

// ----- hdl/pffa_back.sv -----
// pffa_back: job store, node free table, ordering scan and first-fit search
// depends on pffa_pkg, pffa_channels and pffa_ram
module pffa_back #(
   parameter int unsigned NODE_COUNT  = pffa_pkg::NODE_COUNT_DEF,
   parameter int unsigned QUEUE_DEPTH = pffa_pkg::QUEUE_DEPTH_DEF
) (
   input  logic                               clock,
   input  logic                               reset,
   input  pffa_pkg::cmd_type                  cmd_in,
   input  logic                               cmd_valid,
   output logic                               cmd_ready,
   pffa_csr_if.sink                           csr_ch,
   pffa_rsp_if.source                         rsp_ch,
   output logic [$clog2(QUEUE_DEPTH+1)-1:0]   queue_count
);
   import pffa_pkg::*;

   localparam int unsigned QAW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
   localparam int unsigned QCW = $clog2(QUEUE_DEPTH + 1);
   localparam int unsigned NAW = (NODE_COUNT > 1) ? $clog2(NODE_COUNT) : 1;
   localparam int unsigned NLW = $clog2(NODE_COUNT + 1);
   localparam int unsigned LW  = (NLW > 8) ? NLW : 8;

   back_state_type    state_ff, state_in;
   cmd_type           cmd_ff;
   logic [1:0]        policy_ff;
   logic [7:0]        cap_cores_ff;
   logic [9:0]        cap_mem_ff;
   logic [7:0]        nodes_ff;
   logic [NODE_COUNT-1:0] vcore_ff, vmem_ff;
   logic [QCW-1:0]    count_ff, total_ff, round_ff;
   logic [QAW-1:0]    scan_ff, best_idx_ff;
   logic [QUEUE_DEPTH-1:0] taken_ff;
   logic              found_ff;
   job_type           best_ff;
   logic [NAW-1:0]    node_ff, res_node_ff;
   status_type        res_status_ff;
   logic              out_valid_ff, out_last_ff;
   logic [15:0]       out_job_ff;
   status_type        out_status_ff;
   logic [6:0]        out_node_ff;

   logic              job_we;
   job_type           job_wdata, job_rd;
   logic              node_we;
   logic [NAW-1:0]    node_addr;
   logic [NODE_W-1:0] node_wdata, node_rdata;

   logic              out_free, queue_full, tgt_in_ok;
   logic [LW-1:0]     limit;
   logic              limit_zero, last_scan, last_node, last_round, fit, cand_better;
   logic [7:0]        fc, sat_c;
   logic [9:0]        fm, sat_m;
   logic [8:0]        sum_c;
   logic [10:0]       sum_m;

   // job store and node free table
   pffa_ram #(.WIDTH(JOB_W), .DEPTH(QUEUE_DEPTH)) u_job_ram (
      .clock (clock),
      .we    (job_we),
      .waddr (QAW'(count_ff)),
      .wdata (job_wdata),
      .raddr (scan_ff),
      .rdata (job_rd)
   );

   pffa_ram #(.WIDTH(NODE_W), .DEPTH(NODE_COUNT)) u_node_ram (
      .clock (clock),
      .we    (node_we),
      .waddr (node_addr),
      .wdata (node_wdata),
      .raddr (node_addr),
      .rdata (node_rdata)
   );

   // shared conditions
   always_comb begin
      out_free   = !out_valid_ff || rsp_ch.ready;
      queue_full = (count_ff == QCW'(QUEUE_DEPTH));
      tgt_in_ok  = (11'(cmd_in.target_node) < 11'(NODE_COUNT));
      limit      = (LW'(nodes_ff) < LW'(NODE_COUNT)) ? LW'(nodes_ff) : LW'(NODE_COUNT);
      limit_zero = (limit == '0);
      last_scan  = ((QCW'(scan_ff) + QCW'(1)) == total_ff);
      last_node  = ((LW'(node_ff) + LW'(1)) == limit);
      last_round = ((round_ff + QCW'(1)) == total_ff);
      node_addr  = (state_ff == B_REL_RD || state_ff == B_REL_WR) ?
                   NAW'(cmd_ff.target_node) : node_ff;
      // an entry never written since the last capacity write reads as capacity
      fc         = vcore_ff[node_addr] ? node_rdata[17:10] : cap_cores_ff;
      fm         = vmem_ff[node_addr] ? node_rdata[9:0] : cap_mem_ff;
      fit        = (fc >= best_ff.cores) && (fm >= best_ff.memory);
      cand_better = !taken_ff[scan_ff] &&
                    (!found_ff || (key_of(policy_ff, job_rd) < key_of(policy_ff, best_ff)));
      sum_c      = {1'b0, fc} + {1'b0, cmd_ff.cores};
      sum_m      = {1'b0, fm} + {1'b0, cmd_ff.memory};
      sat_c      = (sum_c > {1'b0, cap_cores_ff}) ? cap_cores_ff : sum_c[7:0];
      sat_m      = (sum_m > {1'b0, cap_mem_ff}) ? cap_mem_ff : sum_m[9:0];
   end

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         B_IDLE: begin
            if (cmd_valid) begin
               case (op_type'(cmd_in.op))
                  OP_ENQUEUE:  state_in = B_ENQ_EMIT;
                  OP_SCHEDULE: state_in = (count_ff == '0) ? B_IDLE : B_SEL_RD;
                  OP_RELEASE:  state_in = tgt_in_ok ? B_REL_RD : B_IDLE;
                  default:     state_in = B_IDLE;
               endcase
            end
         end
         B_ENQ_EMIT: if (out_free) state_in = B_IDLE;
         B_REL_RD:   state_in = B_REL_WR;
         B_REL_WR:   state_in = B_IDLE;
         B_SEL_RD:   state_in = B_SEL_CMP;
         B_SEL_CMP: begin
            if (last_scan) state_in = limit_zero ? B_EMIT : B_NODE_RD;
            else state_in = B_SEL_RD;
         end
         B_NODE_RD:  state_in = B_NODE_CMP;
         B_NODE_CMP: state_in = (fit || last_node) ? B_EMIT : B_NODE_RD;
         B_EMIT: begin
            if (out_free) state_in = last_round ? B_IDLE : B_SEL_RD;
         end
         default:    state_in = B_IDLE;
      endcase
   end

   // outputs
   always_comb begin
      cmd_ready          = (state_ff == B_IDLE);
      job_we             = (state_ff == B_ENQ_EMIT) && out_free && !queue_full;
      job_wdata.job_id   = cmd_ff.job_id;
      job_wdata.cores    = cmd_ff.cores;
      job_wdata.memory   = cmd_ff.memory;
      job_wdata.run_time = cmd_ff.run_time;
      job_wdata.product  = cmd_ff.product;
      node_we            = (state_ff == B_REL_WR) || ((state_ff == B_NODE_CMP) && fit);
      node_wdata         = (state_ff == B_REL_WR) ? {sat_c, sat_m} :
                           {fc - best_ff.cores, fm - best_ff.memory};
      csr_ch.ready       = 1'b1;
      rsp_ch.valid       = out_valid_ff;
      rsp_ch.result_job  = out_job_ff;
      rsp_ch.status      = out_status_ff;
      rsp_ch.chosen_node = out_node_ff;
      rsp_ch.last        = out_last_ff;
      queue_count        = count_ff;
   end

   // control and datapath registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= B_IDLE;
         policy_ff    <= POLICY_RESET;
         cap_cores_ff <= CORES_RESET;
         cap_mem_ff   <= MEMORY_RESET;
         nodes_ff     <= NODES_RESET;
         vcore_ff     <= '0;
         vmem_ff      <= '0;
         count_ff     <= '0;
         out_valid_ff <= 1'b0;
         found_ff     <= 1'b0;
      end else begin
         state_ff <= state_in;
         if (rsp_ch.valid && rsp_ch.ready) out_valid_ff <= 1'b0;
         case (state_ff)
            B_IDLE: begin
               if (cmd_valid) begin
                  cmd_ff   <= cmd_in;
                  round_ff <= '0;
                  taken_ff <= '0;
                  total_ff <= count_ff;
                  scan_ff  <= '0;
                  found_ff <= 1'b0;
               end
            end
            B_ENQ_EMIT: begin
               if (out_free) begin
                  out_valid_ff  <= 1'b1;
                  out_job_ff    <= cmd_ff.job_id;
                  out_status_ff <= queue_full ? ST_FULL : ST_QUEUED;
                  out_node_ff   <= '0;
                  out_last_ff   <= 1'b1;
                  if (!queue_full) count_ff <= count_ff + QCW'(1);
               end
            end
            B_REL_WR: begin
               vcore_ff[node_addr] <= 1'b1;
               vmem_ff[node_addr]  <= 1'b1;
            end
            // pick the smallest key among untaken jobs, earlier entry on ties
            B_SEL_CMP: begin
               if (cand_better) begin
                  best_ff     <= job_rd;
                  best_idx_ff <= scan_ff;
                  found_ff    <= 1'b1;
               end
               if (last_scan) begin
                  node_ff       <= '0;
                  res_status_ff <= ST_NOT_ALLOCATED;
                  res_node_ff   <= '0;
               end else begin
                  scan_ff <= scan_ff + QAW'(1);
               end
            end
            // first-fit over the nodes in use
            B_NODE_CMP: begin
               if (fit) begin
                  vcore_ff[node_addr] <= 1'b1;
                  vmem_ff[node_addr]  <= 1'b1;
                  res_status_ff       <= ST_ALLOCATED;
                  res_node_ff         <= node_ff;
               end else if (!last_node) begin
                  node_ff <= node_ff + NAW'(1);
               end
            end
            B_EMIT: begin
               if (out_free) begin
                  out_valid_ff          <= 1'b1;
                  out_job_ff            <= best_ff.job_id;
                  out_status_ff         <= res_status_ff;
                  out_node_ff           <= 7'(res_node_ff);
                  out_last_ff           <= last_round;
                  taken_ff[best_idx_ff] <= 1'b1;
                  round_ff              <= round_ff + QCW'(1);
                  found_ff              <= 1'b0;
                  scan_ff               <= '0;
                  if (last_round) count_ff <= '0;
               end
            end
            default: ;
         endcase
         // register writes; a capacity write reloads every node
         if (csr_ch.valid) begin
            case (csr_ch.index)
               REG_POLICY: policy_ff <= csr_ch.data[1:0];
               REG_CORES: begin
                  cap_cores_ff <= csr_ch.data[7:0];
                  vcore_ff     <= '0;
               end
               REG_MEMORY: begin
                  cap_mem_ff <= csr_ch.data;
                  vmem_ff    <= '0;
               end
               REG_NODES:  nodes_ff <= csr_ch.data[7:0];
               default: ;
            endcase
         end
      end
   end
endmodule

// ----- sim/priority_first_fit_job_allocator_core_tb.sv -----
// testbench for priority_first_fit_job_allocator_core: directed table then random items,
// every result checked against a local allocator model; depends on pffa_pkg, pffa_channels
`timescale 1ns / 100ps
module priority_first_fit_job_allocator_core_tb;
   import pffa_pkg::*;

   localparam int NODES = 128;
   localparam int QDEPTH = 16;
   localparam int WATCHDOG = 200000;

   typedef struct {
      logic [15:0] id;
      logic [1:0]  st;
      logic [6:0]  node;
      logic        last;
   } alloc_result_type;

   typedef struct {
      logic [1:0]  op;
      logic [15:0] id;
      logic [7:0]  cores;
      logic [9:0]  mem;
      logic [15:0] rt;
      logic [6:0]  tgt;
      logic        typed;   // row carries a typed-in expectation
      logic [1:0]  st;
   } stim_row_type;

   typedef struct {
      logic [15:0] id;
      logic [7:0]  cores;
      logic [9:0]  mem;
      logic [15:0] rt;
   } queued_job_type;

   logic clock = 1'b0;
   logic reset = 1'b1;

   pffa_req_if req_ch ();
   pffa_rsp_if rsp_ch ();
   pffa_csr_if csr_ch ();

   priority_first_fit_job_allocator_core dut (
      .clock  (clock),
      .reset  (reset),
      .req_ch (req_ch.sink),
      .rsp_ch (rsp_ch.source),
      .csr_ch (csr_ch.sink)
   );

   always #5 clock = ~clock;

   // model state
   logic [1:0]       mdl_policy;
   logic [7:0]       mdl_cap_cores;
   logic [9:0]       mdl_cap_mem;
   logic [7:0]       mdl_nodes;
   queued_job_type   mdl_queue [$];
   logic [7:0]       mdl_free_cores [NODES];
   logic [9:0]       mdl_free_mem [NODES];
   alloc_result_type expected_results [$];

   int  failures = 0;
   int  idle_cycles = 0;
   bit  hold_off = 0;
   int  queued_now;

   function automatic logic [33:0] order_key(queued_job_type j);
      case (policy_type'(mdl_policy))
         POL_PRODUCT: order_key = 34'(j.rt) * 34'(j.cores) * 34'(j.mem);
         POL_RUNTIME: order_key = 34'(j.rt);
         default:     order_key = '0;
      endcase
   endfunction

   // model: apply one item, queue up its expected results
   task automatic predict_allocation(stim_row_type r);
      queued_job_type j;
      alloc_result_type res;
      int best, lim, total;
      logic [8:0] c;
      logic [10:0] m;
      case (op_type'(r.op))
         OP_ENQUEUE: begin
            res.id = r.id; res.node = '0; res.last = 1'b1;
            if (mdl_queue.size() >= QDEPTH) res.st = ST_FULL;
            else begin
               j.id = r.id; j.cores = r.cores; j.mem = r.mem; j.rt = r.rt;
               mdl_queue = {mdl_queue, j};
               res.st = ST_QUEUED;
            end
            expected_results = {expected_results, res};
         end
         OP_SCHEDULE: begin
            lim = (mdl_nodes < NODES) ? mdl_nodes : NODES;
            total = mdl_queue.size();
            for (int k = 0; k < total; k++) begin
               // queue order is arrival order, so strict less keeps ties early
               best = 0;
               for (int i = 1; i < mdl_queue.size(); i++)
                  if (order_key(mdl_queue[i]) < order_key(mdl_queue[best])) best = i;
               j = mdl_queue[best];
               mdl_queue.delete(best);
               res.id = j.id; res.st = ST_NOT_ALLOCATED; res.node = '0;
               res.last = (k == total - 1);
               for (int n = 0; n < lim; n++)
                  if (mdl_free_cores[n] >= j.cores && mdl_free_mem[n] >= j.mem) begin
                     mdl_free_cores[n] -= j.cores;
                     mdl_free_mem[n] -= j.mem;
                     res.st = ST_ALLOCATED; res.node = 7'(n);
                     break;
                  end
               expected_results = {expected_results, res};
            end
         end
         OP_RELEASE: begin
            c = mdl_free_cores[r.tgt] + r.cores;
            m = mdl_free_mem[r.tgt] + r.mem;
            mdl_free_cores[r.tgt] = (c > mdl_cap_cores) ? mdl_cap_cores : c[7:0];
            mdl_free_mem[r.tgt] = (m > mdl_cap_mem) ? mdl_cap_mem : m[9:0];
         end
         default: ;
      endcase
   endtask

   // valid is left high; the caller drops it after the last write
   task automatic write_register(logic [7:0] idx, logic [9:0] val);
      csr_ch.valid <= 1'b1; csr_ch.index <= idx; csr_ch.data <= val;
      do @(posedge clock); while (!csr_ch.ready);
      case (idx)
         REG_POLICY: mdl_policy = val[1:0];
         REG_CORES: begin
            mdl_cap_cores = val[7:0];
            foreach (mdl_free_cores[n]) mdl_free_cores[n] = val[7:0];
         end
         REG_MEMORY: begin
            mdl_cap_mem = val;
            foreach (mdl_free_mem[n]) mdl_free_mem[n] = val;
         end
         REG_NODES: mdl_nodes = val[7:0];
         default: ;
      endcase
   endtask

   function automatic logic [1:0] expected_st_of(stim_row_type r);
      return (mdl_queue.size() >= QDEPTH) ? ST_FULL : ST_QUEUED;
   endfunction

   // send one item after a random gap; valid only drops when there is a gap
   task automatic send_item(stim_row_type r);
      int gap;
      gap = $urandom_range(0, 9);
      if ($urandom_range(0, 3) == 0) gap = 0;
      if (gap > 0) begin
         req_ch.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_ch.valid <= 1'b1;
      req_ch.op <= r.op; req_ch.job_id <= r.id; req_ch.cores_needed <= r.cores;
      req_ch.memory_needed <= r.mem; req_ch.run_time <= r.rt; req_ch.target_node <= r.tgt;
      do @(posedge clock); while (!req_ch.ready);
      if (r.typed && r.st != expected_st_of(r)) begin
         $error("typed status: expected %0d model %0d", r.st, expected_st_of(r));
         failures++;
      end
      predict_allocation(r);
   endtask

   task automatic drain_wait();
      req_ch.valid <= 1'b0;
      while (expected_results.size() != 0) @(posedge clock);
      repeat (600) @(posedge clock);
   endtask

   function automatic stim_row_type job_row(logic [15:0] id, logic [7:0] c, logic [9:0] m,
                                            logic [15:0] rt);
      stim_row_type r;
      r.op = OP_ENQUEUE; r.id = id; r.cores = c; r.mem = m; r.rt = rt;
      r.tgt = 7'($urandom); r.typed = 1'b0; r.st = ST_QUEUED;
      return r;
   endfunction

   function automatic stim_row_type cmd_row(logic [1:0] op, logic [6:0] tgt, logic [7:0] c,
                                            logic [9:0] m);
      stim_row_type r;
      r.op = op; r.id = 16'($urandom); r.cores = c; r.mem = m; r.rt = 16'($urandom);
      r.tgt = tgt; r.typed = 1'b0; r.st = ST_QUEUED;
      return r;
   endfunction

   function automatic stim_row_type random_job();
      stim_row_type r;
      r = job_row(16'($urandom), 8'($urandom_range(0, 12)), 10'($urandom_range(0, 40)),
                  16'($urandom));
      if ($urandom_range(0, 7) == 0) r.cores = 8'($urandom);
      if ($urandom_range(0, 7) == 0) r.mem = 10'($urandom);
      if ($urandom_range(0, 3) == 0) r.rt = 16'($urandom_range(0, 3));
      return r;
   endfunction

   // result receiver with random stalls
   initial begin
      int gap;
      rsp_ch.ready = 1'b0;
      @(negedge reset);
      forever begin
         gap = $urandom_range(0, 9);
         if ($urandom_range(0, 3) == 0) gap = 0;
         if (gap > 0 || hold_off) begin
            rsp_ch.ready <= 1'b0;
            repeat (gap) @(posedge clock);
            while (hold_off) @(posedge clock);
         end
         rsp_ch.ready <= 1'b1;
         do @(posedge clock); while (!rsp_ch.valid);
      end
   end

   // result checker
   always @(posedge clock) begin
      alloc_result_type e;
      if (!reset && rsp_ch.valid && rsp_ch.ready) begin
         if (expected_results.size() == 0) begin
            $error("result with no item waiting: job %0d", rsp_ch.result_job);
            failures++;
         end else begin
            e = expected_results.pop_front();
            if (rsp_ch.result_job !== e.id) begin
               $error("result_job expected %0d actual %0d", e.id, rsp_ch.result_job);
               failures++;
            end
            if (rsp_ch.status !== e.st) begin
               $error("status expected %0d actual %0d", e.st, rsp_ch.status);
               failures++;
            end
            if (rsp_ch.chosen_node !== e.node) begin
               $error("chosen_node expected %0d actual %0d", e.node, rsp_ch.chosen_node);
               failures++;
            end
            if (rsp_ch.last !== e.last) begin
               $error("last expected %0d actual %0d", e.last, rsp_ch.last);
               failures++;
            end
         end
      end
   end

   // watchdog on cycles with nothing accepted
   always @(posedge clock) begin
      if ((req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready) ||
          (csr_ch.valid && csr_ch.ready) || reset) idle_cycles <= 0;
      else idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= WATCHDOG) begin
         $display("SCOREBOARD MISMATCH");
         $finish;
      end
   end

   // main stimulus
   initial begin
      stim_row_type table_rows [$];
      stim_row_type r;
      logic [9:0] settings [4][4];
      req_ch.valid = 1'b0; req_ch.op = OP_ENQUEUE; req_ch.job_id = '0;
      req_ch.cores_needed = '0; req_ch.memory_needed = '0; req_ch.run_time = '0;
      req_ch.target_node = '0;
      csr_ch.valid = 1'b0; csr_ch.index = '0; csr_ch.data = '0;
      mdl_policy = POLICY_RESET; mdl_cap_cores = CORES_RESET; mdl_cap_mem = MEMORY_RESET;
      mdl_nodes = NODES_RESET;
      foreach (mdl_free_cores[n]) begin
         mdl_free_cores[n] = CORES_RESET; mdl_free_mem[n] = MEMORY_RESET;
      end
      repeat (6) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed: extremes, full queue, every op, empty schedule
      table_rows = {table_rows, cmd_row(OP_SCHEDULE, 0, 0, 0)};
      r = job_row(16'hFFFF, 8'd255, 10'd1023, 16'hFFFF); r.typed = 1;
      table_rows = {table_rows, r};
      r = job_row(16'h0000, 8'd0, 10'd0, 16'h0000); r.typed = 1;
      table_rows = {table_rows, r};
      r = job_row(16'h0024, 8'd24, 10'd64, 16'd5);
      table_rows = {table_rows, r};
      for (int i = 0; i < 13; i++)
         table_rows = {table_rows, job_row(16'(100 + i), 8'd3, 10'd9, 16'(i % 3))};
      r = job_row(16'hBEEF, 8'd1, 10'd1, 16'd1); r.typed = 1; r.st = ST_FULL;
      table_rows = {table_rows, r};
      table_rows = {table_rows, cmd_row(OP_SCHEDULE, 0, 0, 0)};
      table_rows = {table_rows, cmd_row(OP_RELEASE, 7'd0, 8'd255, 10'd1023)};
      table_rows = {table_rows, cmd_row(OP_RELEASE, 7'd127, 8'd1, 10'd1)};
      table_rows = {table_rows, cmd_row(OP_NONE, 7'd5, 8'd7, 10'd7)};
      table_rows = {table_rows, job_row(16'h1234, 8'd24, 10'd64, 16'd2)};
      table_rows = {table_rows, cmd_row(OP_SCHEDULE, 0, 0, 0)};
      foreach (table_rows[i]) send_item(table_rows[i]);
      drain_wait();

      // settings: policy, cores, memory, nodes
      settings[0] = '{10'd1, 10'd255, 10'd1023, 10'd1};
      settings[1] = '{10'd2, 10'd1, 10'd1, 10'd128};
      settings[2] = '{10'd3, 10'd16, 10'd48, 10'd0};
      settings[3] = '{10'd1, 10'd20, 10'd60, 10'd8};
      for (int ph = 0; ph < 4; ph++) begin
         for (int k = 0; k < 4; k++) write_register(8'(k), settings[ph][k]);
         write_register(8'd9, 10'h3FF);
         csr_ch.valid <= 1'b0;
         for (int s = 0; s < 6; s++) begin
            // well-formed batch: jobs, perhaps a no-op, a schedule, then up to three releases
            queued_now = $urandom_range(1, 12);
            if (ph == 1 && s == 0) begin
               // long receiver hold-off while the sender keeps going
               hold_off = 1;
               fork
                  begin repeat (400) @(posedge clock); hold_off = 0; end
               join_none
               queued_now = 16;
            end
            for (int q = 0; q < queued_now; q++) send_item(random_job());
            if ($urandom_range(0, 3) == 0) send_item(cmd_row(OP_NONE, 7'($urandom),
                                                             8'($urandom), 10'($urandom)));
            send_item(cmd_row(OP_SCHEDULE, 0, 0, 0));
            repeat ($urandom_range(0, 3))
               send_item(cmd_row(OP_RELEASE, 7'($urandom_range(0, 9)), 8'($urandom),
                                 10'($urandom)));
         end
         // noise: any op, random fields
         for (int q = 0; q < 18; q++) begin
            r = random_job(); r.op = 2'($urandom); r.tgt = 7'($urandom);
            send_item(r);
         end
         send_item(cmd_row(OP_SCHEDULE, 0, 0, 0));
         drain_wait();
      end

      if (expected_results.size() != 0) begin
         $error("results never arrived: %0d", expected_results.size());
         failures++;
      end
      if (failures == 0) $display("SCOREBOARD CLEAN");
      else $display("SCOREBOARD MISMATCH");
      $finish;
   end

endmodule
